// ===== hw/rtl/adaptive_range_encoder_core_defines.svh =====
// Assertion macros shared by the checker of the adaptive range encoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ADAPTIVE_RANGE_ENCODER_CORE_DEFINES_SVH
`define ADAPTIVE_RANGE_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARE_ASSERT_NOW(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (b)) else $error("are assertion failed");

// Next-cycle implication, disabled during reset.
`define ARE_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (b)) else $error("are assertion failed");

`endif

// ===== hw/rtl/are_pkg.sv =====
// Package for the adaptive range encoder: payload types, constants and
// controller/datapath interface structs. No dependencies.
`default_nettype none
package are_pkg;
    localparam int VALUE_BITS  = 16;
    localparam int TABLE_DEPTH = 65;
    localparam int NUM_TABLES  = 3;
    localparam int STORE_DEPTH = NUM_TABLES * TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WEIGHT_W    = 12;
    localparam int SUFFIX_BASE = 33;
    localparam int FLUSH_BYTES = 5;

    localparam logic [1:0] ACT_TYPE  = 2'd0;
    localparam logic [1:0] ACT_UNIV  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [WEIGHT_W-1:0] PROB_HALF = 12'h800;
    localparam logic [12:0]         PROB_ONE  = 13'h1000;
    localparam logic [31:0]         TOP_RANGE = 32'h0100_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  table_req;
        logic        bit_value;
        logic [15:0] value;
        logic [3:0]  shift_prefix;
        logic [3:0]  shift_suffix;
    } are_in_t;

    typedef struct packed {
        logic [7:0]  first_byte;
        logic [7:0]  fill_byte;
        logic [31:0] fill_count;
        logic        last;
    } are_out_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic mul;
        logic upd;
        logic shift;
        logic norm;
        logic adv;
        logic finish;
    } are_cmd_t;

    typedef struct packed {
        logic act_code;
        logic act_flush;
        logic need_norm;
        logic seq_last;
        logic out_free;
        logic hold_valid;
    } are_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/are_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module are_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 195
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/are_ctrl.sv =====
// Controller state machine of the adaptive range encoder.
// Depends on are_pkg.
`default_nettype none
module are_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire are_pkg::are_status_t sts,
    output are_pkg::are_cmd_t        cmd
);
    import are_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_UPD    = 8'b0001_0000,
        S_NORM   = 8'b0010_0000,
        S_FLUSH  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                if (sts.act_code)
                begin
                    state_next = S_READ;
                end
                else if (sts.act_flush)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.need_norm)
                begin
                    if (sts.out_free)
                    begin
                        cmd.shift = 1'b1;
                        cmd.norm  = 1'b1;
                    end
                end
                else if (sts.seq_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(FLUSH_BYTES - 1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/are_datapath.sv =====
// Datapath of the adaptive range encoder: coder state, weight store,
// bit sequencing and the result registers. Depends on are_pkg and are_ram.
`default_nettype none
module are_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire are_pkg::are_in_t     in_data,
    input  wire are_pkg::are_cmd_t    cmd,
    output are_pkg::are_status_t      sts,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output are_pkg::are_out_t         out_data
);
    import are_pkg::*;

    logic [1:0]  act_reg;
    logic [1:0]  tbl_reg;
    logic        bitv_reg;
    logic [15:0] val_reg;
    logic [3:0]  sh1_reg;
    logic [3:0]  sh2_reg;
    logic [4:0]  n_reg;
    logic [4:0]  n_next;
    logic [5:0]  pos_reg;

    logic [31:0] range_reg;
    logic [32:0] low_reg;
    logic [7:0]  cache_reg;
    logic [31:0] pend_reg;
    logic [WEIGHT_W-1:0] type_w_reg;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic        vq_reg;
    logic [31:0] thr_reg;
    logic [WEIGHT_W-1:0] wt_reg;

    logic        hold_valid_reg;
    are_out_t    hold_reg;
    logic        out_valid_reg;
    are_out_t    out_reg;

    logic [WEIGHT_W-1:0] ram_q;
    logic [ADDR_W-1:0]   addr;
    logic [6:0]  idx;
    logic [5:0]  total;
    logic [5:0]  sfx;
    logic        cur_bit;
    logic [3:0]  cur_sh;
    logic [3:0]  eff_sh;
    logic        is_type;
    logic        is_code;
    logic [WEIGHT_W-1:0] wt_in;
    logic [WEIGHT_W-1:0] wt_new;
    logic        ram_we;
    logic        carry;
    logic        emit;
    logic        out_free;
    are_out_t    res;

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (in_data.value[i])
            begin
                n_next = 5'(i + 1);
            end
        end
    end

    assign is_type = (act_reg == ACT_TYPE);
    assign is_code = is_type || ((act_reg == ACT_UNIV) && (tbl_reg < 2'(NUM_TABLES)));
    assign total   = (n_reg == 5'd0) ? 6'd1 : {n_reg, 1'b0};
    assign sfx     = {n_reg, 1'b0} - 6'd1 - pos_reg;

    always_comb
    begin
        if (is_type)
        begin
            cur_bit = bitv_reg;
            idx     = '0;
            cur_sh  = sh1_reg;
        end
        else if (pos_reg < {1'b0, n_reg})
        begin
            cur_bit = 1'b1;
            idx     = {1'b0, pos_reg};
            cur_sh  = sh1_reg;
        end
        else if (pos_reg == {1'b0, n_reg})
        begin
            cur_bit = 1'b0;
            idx     = {1'b0, pos_reg};
            cur_sh  = sh1_reg;
        end
        else
        begin
            cur_bit = val_reg[sfx[3:0]];
            idx     = 7'(SUFFIX_BASE) + {1'b0, sfx};
            cur_sh  = sh2_reg;
        end
    end

    assign eff_sh = (cur_sh == 4'd0) ? 4'd1 : cur_sh;
    assign addr   = ADDR_W'(tbl_reg) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(idx);
    assign wt_in  = is_type ? type_w_reg : (vq_reg ? ram_q : PROB_HALF);
    assign wt_new = cur_bit ? (wt_reg - (wt_reg >> eff_sh))
                            : (wt_reg + WEIGHT_W'((PROB_ONE - {1'b0, wt_reg}) >> eff_sh));
    assign ram_we = cmd.upd && !is_type;

    are_ram #(
        .WIDTH(WEIGHT_W),
        .DEPTH(STORE_DEPTH)
    ) u_weights (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr),
        .wdata(wt_new),
        .raddr(addr),
        .rdata(ram_q)
    );

    assign carry = low_reg[32];
    assign emit  = (low_reg[31:24] != 8'hFF) || carry;
    assign res.first_byte = cache_reg + {7'd0, carry};
    assign res.fill_byte  = carry ? 8'h00 : 8'hFF;
    assign res.fill_count = pend_reg - 32'd1;
    assign res.last       = 1'b0;

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.act_code   = is_code;
    assign sts.act_flush  = (act_reg == ACT_FLUSH);
    assign sts.need_norm  = (range_reg < TOP_RANGE);
    assign sts.seq_last   = ((pos_reg + 6'd1) == total) || is_type;
    assign sts.out_free   = out_free;
    assign sts.hold_valid = hold_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_data.action;
            tbl_reg  <= in_data.table_req;
            bitv_reg <= in_data.bit_value;
            val_reg  <= in_data.value;
            sh1_reg  <= in_data.shift_prefix;
            sh2_reg  <= in_data.shift_suffix;
            n_reg    <= n_next;
        end
        if (cmd.rd)
        begin
            vq_reg <= valid_reg[addr];
        end
        if (cmd.mul)
        begin
            thr_reg <= 32'(range_reg[31:12] * wt_in);
            wt_reg  <= wt_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            range_reg      <= 32'hFFFF_FFFF;
            low_reg        <= '0;
            cache_reg      <= 8'hFF;
            pend_reg       <= '0;
            type_w_reg     <= PROB_HALF;
            valid_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= '0;
            end
            else if (cmd.adv)
            begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (cmd.upd)
            begin
                if (cur_bit)
                begin
                    range_reg <= range_reg - thr_reg;
                    low_reg   <= low_reg + {1'b0, thr_reg};
                end
                else
                begin
                    range_reg <= thr_reg;
                end
                if (is_type)
                begin
                    type_w_reg <= wt_new;
                end
                else
                begin
                    valid_reg[addr] <= 1'b1;
                end
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.shift)
            begin
                if (cmd.norm)
                begin
                    range_reg <= {range_reg[23:0], 8'h00};
                end
                low_reg <= {1'b0, low_reg[23:0], 8'h00};
                if (emit)
                begin
                    cache_reg <= low_reg[31:24];
                    pend_reg  <= 32'd1;
                    if (pend_reg != 32'd0)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_reg       <= hold_reg;
                            out_valid_reg <= 1'b1;
                        end
                        hold_reg       <= res;
                        hold_valid_reg <= 1'b1;
                    end
                end
                else if (pend_reg != 32'hFFFF_FFFF)
                begin
                    pend_reg <= pend_reg + 32'd1;
                end
            end

            if (cmd.finish)
            begin
                out_reg       <= '{first_byte: hold_reg.first_byte,
                                   fill_byte:  hold_reg.fill_byte,
                                   fill_count: hold_reg.fill_count,
                                   last:       1'b1};
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/adaptive_range_encoder_core.sv =====
// Top level of the adaptive range encoder: controller plus datapath.
// Depends on are_pkg, are_ctrl and are_datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  are_in_t
//   out      output     out_valid/out_stall are_out_t
//
// A coded bit passes through the weight read, multiply, update and check states,
// where the check state does any normalizing byte shifts; a universal code of an
// n-bit value codes 2n bits (one bit for zero). A flush shifts out five bytes.
// Each item also passes through the accept, decode and finish states. Byte shifts wait for a free output.
// Reset sets the coder state and marks every stored weight as 0x800 at once.
// A stalled output holds the byte shift that would produce the next transaction.
`default_nettype none
module adaptive_range_encoder_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire are_pkg::are_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output are_pkg::are_out_t     out_data
);
    import are_pkg::*;

    are_cmd_t    cmd;
    are_status_t sts;

    are_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    are_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/are_checker.sv =====
// Port-level checker for the adaptive range encoder, bound to the top level.
// Depends on are_pkg and adaptive_range_encoder_core_defines.svh.
`default_nettype none
`include "adaptive_range_encoder_core_defines.svh"
module are_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire are_pkg::are_out_t out_data
);
    import are_pkg::*;

    `ARE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `ARE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `ARE_ASSERT_NOW(a_fill_code, out_valid, out_data.fill_byte == 8'hFF || out_data.fill_byte == 8'h00)
    `ARE_ASSERT_NOW(a_idle_no_new, out_valid && !in_stall, out_data.last)
endmodule

bind adaptive_range_encoder_core are_checker u_are_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
`default_nettype wire

// ===== tb/tb_adaptive_range_encoder_core.sv =====
// Testbench for adaptive_range_encoder_core: drives coding transactions and checks
// every emitted byte run against a behavioral range coder held in a scoreboard class.
// Depends on are_pkg and the RTL of adaptive_range_encoder_core.
`default_nettype none
module tb_adaptive_range_encoder_core;
    import are_pkg::*;

    localparam int IN_W = $bits(are_in_t);

    class byte_run_board;
        logic [31:0] rng;
        logic [32:0] lo;
        logic [7:0]  cache;
        logic [31:0] pend;
        logic [11:0] type_w;
        logic [11:0] weights [STORE_DEPTH];
        are_out_t    runs [$];
        are_out_t    fresh [$];
        int          errors;

        function void clear_coder();
            rng = 32'hFFFF_FFFF;
            lo = '0;
            cache = 8'hFF;
            pend = '0;
            type_w = PROB_HALF;
            foreach (weights[k]) weights[k] = PROB_HALF;
            errors = 0;
        endfunction

        function void shift_byte();
            logic carry;
            are_out_t r;
            carry = lo[32];
            if (lo[31:0] < 32'hFF00_0000 || carry) begin
                if (pend != 0) begin
                    r.first_byte = cache + carry;
                    r.fill_byte = 8'hFF + carry;
                    r.fill_count = pend - 1;
                    r.last = 1'b0;
                    fresh.push_back(r);
                end
                pend = '0;
                cache = lo[31:24];
            end
            if (pend != 32'hFFFF_FFFF) pend++;
            lo = {1'b0, lo[23:0], 8'h00};
        endfunction

        function logic [11:0] code_one(logic b, logic [11:0] w, logic [3:0] sh);
            logic [31:0] thr;
            int s;
            s = (sh == 0) ? 1 : sh;
            thr = (rng >> 12) * w;
            if (!b) begin
                rng = thr;
                w = w + ((13'h1000 - w) >> s);
            end else begin
                rng = rng - thr;
                lo = lo + thr;
                w = w - (w >> s);
            end
            while (rng < TOP_RANGE) begin
                rng = rng << 8;
                shift_byte();
            end
            return w;
        endfunction

        function void note_input(are_in_t t);
            int base, n;
            logic [15:0] v;
            fresh.delete();
            if (t.action == ACT_TYPE)
                type_w = code_one(t.bit_value, type_w, t.shift_prefix);
            else if (t.action == ACT_UNIV && t.table_req < NUM_TABLES) begin
                base = t.table_req * TABLE_DEPTH;
                v = t.value;
                n = 0;
                while (v != 0) begin
                    weights[base+n] = code_one(1'b1, weights[base+n], t.shift_prefix);
                    v = v >> 1;
                    n++;
                end
                weights[base+n] = code_one(1'b0, weights[base+n], t.shift_prefix);
                for (int i = n - 2; i >= 0; i--)
                    weights[base+SUFFIX_BASE+i] =
                        code_one(t.value[i], weights[base+SUFFIX_BASE+i], t.shift_suffix);
            end else if (t.action == ACT_FLUSH)
                for (int k = 0; k < FLUSH_BYTES; k++) shift_byte();
            if (fresh.size() > 0) fresh[$].last = 1'b1;
            foreach (fresh[k]) runs.push_back(fresh[k]);
        endfunction

        task check_result(are_out_t got);
            are_out_t want;
            if (runs.size() == 0) begin
                report("unexpected transaction", got, got);
                return;
            end
            want = runs.pop_front();
            if (got !== want) report("byte run mismatch", got, want);
        endtask

        task report(string what, are_out_t got, are_out_t want);
            $display("ERROR %s: got %h/%h/%0d/%b want %h/%h/%0d/%b", what,
                     got.first_byte, got.fill_byte, got.fill_count, got.last,
                     want.first_byte, want.fill_byte, want.fill_count, want.last);
            errors++;
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    are_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    are_out_t out_data;
    byte_run_board board;
    bit       calm = 1'b0;
    int       sent = 0;

    adaptive_range_encoder_core uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    end

    initial
    begin
        int idle;
        @(negedge clk);
        while (1)
        begin
            if (!calm && $urandom_range(0, 9) == 0) begin
                idle = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (idle) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(negedge clk);
        end
    end

    task automatic send(are_in_t t);
        int idle;
        if (!calm && $urandom_range(0, 7) == 0) begin
            idle = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_data <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(t);
        sent++;
        @(negedge clk);
    endtask

    function automatic are_in_t make(logic [1:0] a, logic [1:0] tb, logic b,
                                     logic [15:0] v, logic [3:0] s1, logic [3:0] s2);
        are_in_t t;
        t.action = a;
        t.table_req = tb;
        t.bit_value = b;
        t.value = v;
        t.shift_prefix = s1;
        t.shift_suffix = s2;
        return t;
    endfunction

    function automatic are_in_t random_item();
        are_in_t t;
        int r;
        t = are_in_t'(IN_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 35) t.action = ACT_TYPE;
        else if (r < 88) t.action = ACT_UNIV;
        else if (r < 96) t.action = ACT_FLUSH;
        else t.action = 2'd3;
        if (t.action == ACT_UNIV && $urandom_range(0, 19) != 0)
            t.table_req = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) t.value = t.value >> $urandom_range(0, 15);
        if ($urandom_range(0, 3) != 0) begin
            t.shift_prefix = 4'($urandom_range(3, 6));
            t.shift_suffix = 4'($urandom_range(3, 6));
        end
        return t;
    endfunction

    initial
    begin
        board = new();
        board.clear_coder();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        send(make(ACT_TYPE, 0, 0, 0, 4'd5, 4'd5));
        send(make(ACT_TYPE, 0, 1, 0, 4'd1, 4'd1));
        send(make(ACT_TYPE, 0, 1, 0, 4'd0, 4'd0));
        send(make(ACT_TYPE, 0, 0, 0, 4'd15, 4'd15));
        send(make(ACT_UNIV, 0, 0, 16'd0, 4'd4, 4'd4));
        send(make(ACT_UNIV, 1, 0, 16'd1, 4'd0, 4'd0));
        send(make(ACT_UNIV, 2, 1, 16'hFFFF, 4'd15, 4'd15));
        send(make(ACT_UNIV, 0, 0, 16'h8000, 4'd1, 4'd1));
        send(make(ACT_UNIV, 3, 1, 16'h1234, 4'd5, 4'd5));
        send(make(2'd3, 3, 1, 16'hFFFF, 4'd15, 4'd15));
        send(make(ACT_FLUSH, 0, 0, 0, 4'd5, 4'd5));
        send(make(ACT_FLUSH, 0, 0, 0, 4'd5, 4'd5));
        for (int k = 0; k < 30; k++)
            send(make(ACT_TYPE, 0, 1, 0, 4'd1, 4'd1));
        for (int k = 0; k < 20; k++)
            send(make(ACT_UNIV, 2, 0, 16'hFFFF, 4'd1, 4'd1));
        send(make(ACT_FLUSH, 0, 0, 0, 4'd5, 4'd5));
        for (int k = 0; k < 400; k++)
        begin
            if (k == 340) calm = 1'b1;
            send(random_item());
        end
        send(make(ACT_FLUSH, 0, 0, 0, 4'd5, 4'd5));
        in_valid <= 1'b0;
        while (board.runs.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.runs.size() == 0)
            $display("PASS adaptive_range_encoder_core");
        else
            $display("FAIL adaptive_range_encoder_core");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("FAIL adaptive_range_encoder_core");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/are_pkg.sv
hw/rtl/are_ram.sv
hw/rtl/are_ctrl.sv
hw/rtl/are_datapath.sv
hw/rtl/adaptive_range_encoder_core.sv
hw/rtl/are_checker.sv
tb/tb_adaptive_range_encoder_core.sv
